@@ design/assert_macros.svh @@
// Assertion macros shared by the image rotation address generator RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/irag_pkg.sv @@
// Shared types, register indexes, mode codes and width helpers for the
// image rotation address generator. No dependencies.
package irag_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int SIZE_W     = 11;  // frame and viewport size registers
  localparam int OFFS_W     = 10;  // viewport offset registers
  localparam int MODE_W     = 2;
  localparam int PIX_W      = 16;
  localparam int IDX_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int M_DATA_W   = 40;  // dest_index + pixel_out, padded to bytes

  // Register indexes of the write port.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_COLUMNS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_ROWS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 3'd6;

  // Rotation modes, clockwise.
  localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [OFFS_W-1:0] view_left;
    logic [OFFS_W-1:0] view_top;
    logic [SIZE_W-1:0] view_columns;
    logic [SIZE_W-1:0] view_rows;
    logic [MODE_W-1:0] rotation_mode;
  } irag_cfg_t;

  typedef struct packed {
    logic emit;  // the pixel produces an output word
    logic last;  // it is the last emitted pixel of the frame
  } irag_flag_t;

  // Operand width of the index arithmetic: wide enough for every register
  // and for the clamped frame size.
  function automatic int irag_op_w(input int max_w, input int max_h);
    int ww;
    int hw;
    int r;
    ww = $clog2(max_w + 1);
    hw = $clog2(max_h + 1);
    r  = SIZE_W;
    if (ww > r) r = ww;
    if (hw > r) r = hw;
    return r;
  endfunction

endpackage

@@ design/irag_locate.sv @@
// Position counters and viewport decode for the image rotation address
// generator. Depends on irag_pkg and assert_macros.svh.
`include "assert_macros.svh"
module irag_locate #(
  parameter int MAX_WIDTH  = irag_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = irag_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             clear,
  input  logic                                             step,
  input  irag_pkg::irag_cfg_t                              cfg,
  output irag_pkg::irag_flag_t                             flag,
  output logic [irag_pkg::irag_op_w(MAX_WIDTH, MAX_HEIGHT)-1:0] op_a,
  output logic [irag_pkg::irag_op_w(MAX_WIDTH, MAX_HEIGHT)-1:0] op_b,
  output logic [irag_pkg::irag_op_w(MAX_WIDTH, MAX_HEIGHT)-1:0] addend
);
  import irag_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int OP_W  = irag_op_w(MAX_WIDTH, MAX_HEIGHT);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [OP_W-1:0] w, h, col_x, row_x, vl, vt, vc, vr;
  logic [OP_W-1:0] i, j, ew, eh, ri, rj;
  logic            in_view, wrap_col, wrap_row;

  // Frame size limited to 1..MAX.
  always_comb begin
    if (cfg.source_width == '0) begin
      w = OP_W'(1);
    end else if (OP_W'(cfg.source_width) > OP_W'(MAX_WIDTH)) begin
      w = OP_W'(MAX_WIDTH);
    end else begin
      w = OP_W'(cfg.source_width);
    end
    if (cfg.source_height == '0) begin
      h = OP_W'(1);
    end else if (OP_W'(cfg.source_height) > OP_W'(MAX_HEIGHT)) begin
      h = OP_W'(MAX_HEIGHT);
    end else begin
      h = OP_W'(cfg.source_height);
    end
  end

  assign col_x = OP_W'(col);
  assign row_x = OP_W'(row);
  assign vl    = OP_W'(cfg.view_left);
  assign vt    = OP_W'(cfg.view_top);
  assign vc    = OP_W'(cfg.view_columns);
  assign vr    = OP_W'(cfg.view_rows);

  assign j  = col_x - vl;
  assign i  = row_x - vt;
  assign rj = vc - j - OP_W'(1);
  assign ri = vr - i - OP_W'(1);

  assign in_view = (col_x >= vl) && (j < vc) && (row_x >= vt) && (i < vr);

  // Extent of the viewport that lies inside the frame, per axis.
  always_comb begin
    if (vl >= w) begin
      ew = '0;
    end else if (vc < w - vl) begin
      ew = vc;
    end else begin
      ew = w - vl;
    end
    if (vt >= h) begin
      eh = '0;
    end else if (vr < h - vt) begin
      eh = vr;
    end else begin
      eh = h - vt;
    end
  end

  // Index terms: dest_index = op_a * op_b + addend.
  always_comb begin
    flag.emit = in_view;
    flag.last = in_view && (i + OP_W'(1) == eh) && (j + OP_W'(1) == ew);
    case (cfg.rotation_mode)
      MODE_COPY: begin
        flag.emit = 1'b1;
        flag.last = (row_x == h - OP_W'(1)) && (col_x == w - OP_W'(1));
        op_a      = row_x;
        op_b      = w;
        addend    = col_x;
      end
      MODE_ROT90: begin
        op_a   = j;
        op_b   = vr;
        addend = ri;
      end
      MODE_ROT180: begin
        op_a   = ri;
        op_b   = vc;
        addend = rj;
      end
      MODE_ROT270: begin
        op_a   = rj;
        op_b   = vr;
        addend = i;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        addend = '0;
      end
    endcase
  end

  assign wrap_col = (col_x + OP_W'(1)) >= w;
  assign wrap_row = (row_x + OP_W'(1)) >= h;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (wrap_col) begin
        col <= '0;
        row <= wrap_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Counters stay inside the frame, because every register write clears them.
  `ASSERT_IMPL(a_col_inside, 1'b1, col_x < w, "column counter outside the frame")
  `ASSERT_IMPL(a_row_inside, 1'b1, row_x < h, "row counter outside the frame")

endmodule

@@ design/image_rotate_address_gen_top.sv @@
// Image rotation address generator, top level. Depends on irag_pkg,
// irag_locate and assert_macros.svh.
// An accepted pixel passes through stage one and then stage two, which holds its output word.
// Throughput: one pixel per cycle while the output word is empty or being taken; the index
// multiplier sits alone in the second stage, so the pipeline never blocks on it.
// Reset (synchronous, rst high) loads the register defaults and clears the
// position counters and both pipeline stages.
`include "assert_macros.svh"
module image_rotate_address_gen_top #(
  parameter int MAX_WIDTH  = irag_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = irag_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Register write port.
  input  logic                              wr_en,
  input  logic [irag_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [irag_pkg::CFG_DATA_W-1:0]   wr_data,
  // Source pixels in raster order.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [irag_pkg::PIX_W-1:0]        s_tdata,   // [15:0] pixel_in
  // Destination words.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [irag_pkg::M_DATA_W-1:0]     m_tdata,   // [19:0] dest_index,
                                                       // [35:20] pixel_out,
                                                       // [39:36] zero
  output logic                              m_tlast    // frame_last
);
  import irag_pkg::*;

  localparam int OP_W = irag_op_w(MAX_WIDTH, MAX_HEIGHT);

  // Register file. Any write to a known register also restarts the frame.
  irag_cfg_t cfg;
  logic      cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= SIZE_W'(1024);
      cfg.source_height <= SIZE_W'(1024);
      cfg.view_left     <= '0;
      cfg.view_top      <= '0;
      cfg.view_columns  <= SIZE_W'(1024);
      cfg.view_rows     <= SIZE_W'(1024);
      cfg.rotation_mode <= MODE_COPY;
    end else if (wr_en) begin
      case (wr_index)
        REG_SOURCE_WIDTH:  cfg.source_width  <= wr_data;
        REG_SOURCE_HEIGHT: cfg.source_height <= wr_data;
        REG_VIEW_LEFT:     cfg.view_left     <= wr_data[OFFS_W-1:0];
        REG_VIEW_TOP:      cfg.view_top      <= wr_data[OFFS_W-1:0];
        REG_VIEW_COLUMNS:  cfg.view_columns  <= wr_data;
        REG_VIEW_ROWS:     cfg.view_rows     <= wr_data;
        REG_ROTATION_MODE: cfg.rotation_mode <= wr_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = wr_en && (wr_index <= REG_ROTATION_MODE);

  // Handshake. The pipeline moves whenever the output word is empty or is
  // being taken; the input side is ready whenever the first stage can move.
  logic advance, accept;
  logic s1_valid;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Stage one: position decode and the multiply operands.
  irag_flag_t      flag;
  logic [OP_W-1:0] op_a, op_b, addend;

  irag_locate #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_locate (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_hit),
    .step   (accept),
    .cfg    (cfg),
    .flag   (flag),
    .op_a   (op_a),
    .op_b   (op_b),
    .addend (addend)
  );

  // Only pixels that produce a word enter the first stage; dropped pixels
  // just advance the counters.
  logic             s1_last;
  logic [OP_W-1:0]  s1_a, s1_b, s1_add;
  logic [PIX_W-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept && flag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= flag.last;
      s1_a    <= op_a;
      s1_b    <= op_b;
      s1_add  <= addend;
      s1_pix  <= s_tdata;
    end
  end

  // Stage two: one multiply and add, kept to the low index bits.
  logic [2*OP_W-1:0] product;
  logic [IDX_W-1:0]  dest_next;
  logic [IDX_W-1:0]  dest_index;
  logic [PIX_W-1:0]  pixel_out;
  logic              frame_last;

  assign product   = s1_a * s1_b;
  assign dest_next = product[IDX_W-1:0] + IDX_W'(s1_add);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      dest_index <= dest_next;
      pixel_out  <= s1_pix;
      frame_last <= s1_last;
    end
  end

  assign m_tdata = {{(M_DATA_W - IDX_W - PIX_W){1'b0}}, pixel_out, dest_index};
  assign m_tlast = frame_last;

  // In copy mode every accepted pixel must reach the first stage.
  `ASSERT_NEXT(a_copy_emits, accept && cfg.rotation_mode == MODE_COPY, s1_valid,
               "copy mode pixel was dropped")
  // A stalled first stage keeps its word.
  `ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_pix),
               "stalled pipeline word was lost")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for image_rotate_address_gen_top: a directed table of register
// writes and pixels, then random frames under several idle patterns on both streams.
// Depends on irag_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irag_pkg::*;

  // Index 7 is decoded by nothing. A write to it must leave the scan position alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 386;
  // The block has two pipeline stages, so a few spare cycles cover a dropped pixel
  // that is still in flight when the last expected word has left.
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_GAP        = 20;
  localparam int END_GUARD      = 20000;
  localparam longint LIMIT_NS   = 5_000_000;

  // One destination word as the block should present it.
  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } dest_word_t;

  // One row of the directed table: a register write or a pixel. A pixel row may
  // carry its result typed in by hand. Otherwise the predictor supplies it.
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [PIX_W-1:0]      value;
    bit                    fixed;
    bit                    fixed_emit;
    logic [IDX_W-1:0]      fixed_index;
    bit                    fixed_last;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;   // [15:0] pixel_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;        // [19:0] dest_index, [35:20] pixel_out, [39:36] zero
  logic                  m_tlast;        // frame_last

  image_rotate_address_gen_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the register file and of the raster scan position.
  irag_cfg_t   shadow_regs;
  int unsigned scan_col;
  int unsigned scan_row;

  // Words that the block owes, oldest first.
  dest_word_t  pending_words[$];
  plan_row_t   directed_plan[$];

  int mismatches  = 0;
  int items_sent  = 0;
  bit stream_used = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // The stimulus bumps hold_asks to ask for one long stall of the receiver. The
  // receiver process counts the stall down on its own.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
  endtask

  // A frame size of zero behaves as one, and anything above the maximum as the maximum.
  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // How many viewport lines along one axis still fall inside the frame.
  function automatic int unsigned in_frame_extent(input int unsigned start,
                                                  input int unsigned size,
                                                  input int unsigned frame);
    if (start >= frame) return 0;
    return (size < frame - start) ? size : frame - start;
  endfunction

  // Every write to a known index reloads one register and restarts the frame. A write to an
  // unused index changes nothing at all.
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SOURCE_WIDTH:  shadow_regs.source_width  = val;
      REG_SOURCE_HEIGHT: shadow_regs.source_height = val;
      REG_VIEW_LEFT:     shadow_regs.view_left     = val[OFFS_W-1:0];
      REG_VIEW_TOP:      shadow_regs.view_top      = val[OFFS_W-1:0];
      REG_VIEW_COLUMNS:  shadow_regs.view_columns  = val;
      REG_VIEW_ROWS:     shadow_regs.view_rows     = val;
      REG_ROTATION_MODE: shadow_regs.rotation_mode = val[MODE_W-1:0];
      default:           return;
    endcase
    scan_col = 0;
    scan_row = 0;
  endfunction

  // Works out the destination word of one source pixel, if the pixel is kept,
  // and moves the scan position on by one pixel.
  function automatic bit rotate_pixel(input logic [PIX_W-1:0] pix, output dest_word_t word);
    int unsigned w, h, col, row, vl, vt, vc, vr, i, j, di;
    bit emit, last;
    w  = clamp_size(shadow_regs.source_width, MAX_WIDTH_DEF);
    h  = clamp_size(shadow_regs.source_height, MAX_HEIGHT_DEF);
    col = (scan_col >= w) ? w - 1 : scan_col;
    row = (scan_row >= h) ? h - 1 : scan_row;
    vl = shadow_regs.view_left;
    vt = shadow_regs.view_top;
    vc = shadow_regs.view_columns;
    vr = shadow_regs.view_rows;
    emit = 1'b0;
    last = 1'b0;
    di   = 0;
    if (shadow_regs.rotation_mode == MODE_COPY) begin
      emit = 1'b1;
      di   = row * w + col;
      last = (row == h - 1) && (col == w - 1);
    end else if (col >= vl && col - vl < vc && row >= vt && row - vt < vr) begin
      i = row - vt;
      j = col - vl;
      emit = 1'b1;
      case (shadow_regs.rotation_mode)
        MODE_ROT90:  di = (vr - 1 - i) + j * vr;
        MODE_ROT180: di = (vr - 1 - i) * vc + (vc - 1 - j);
        default:     di = i + (vc - 1 - j) * vr;  // MODE_ROT270
      endcase
      // The viewport may hang over the frame edge; the last kept pixel is then
      // the corner of the part that lies inside.
      last = (i + 1 == in_frame_extent(vt, vr, h)) && (j + 1 == in_frame_extent(vl, vc, w));
    end
    if (col + 1 >= w) begin
      scan_col = 0;
      scan_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      scan_col = col + 1;
      scan_row = row;
    end
    word.dest_index = IDX_W'(di);  // only the low 20 bits survive an overflow
    word.pixel      = pix;
    word.last       = last;
    return emit;
  endfunction

  // Random register values, mostly sized so that whole frames stay short.
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    int unsigned w, h, r;
    w = clamp_size(shadow_regs.source_width, MAX_WIDTH_DEF);
    h = clamp_size(shadow_regs.source_height, MAX_HEIGHT_DEF);
    r = $urandom_range(15);
    case (idx)
      REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: begin
        case (r)
          0:       return '0;
          1:       return '1;
          2:       return CFG_DATA_W'(MAX_WIDTH_DEF);
          3:       return CFG_DATA_W'($urandom);
          default: return CFG_DATA_W'($urandom_range(6, 1));
        endcase
      end
      REG_VIEW_LEFT:    return (r < 2) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(w));
      REG_VIEW_TOP:     return (r < 2) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(h));
      REG_VIEW_COLUMNS: begin
        case (r)
          0:       return '0;
          1:       return '1;
          2:       return CFG_DATA_W'($urandom);
          default: return CFG_DATA_W'($urandom_range(w + 1, 1));
        endcase
      end
      REG_VIEW_ROWS: begin
        case (r)
          0:       return '0;
          1:       return '1;
          2:       return CFG_DATA_W'($urandom);
          default: return CFG_DATA_W'($urandom_range(h + 1, 1));
        endcase
      end
      default:          return CFG_DATA_W'($urandom);  // upper bits of the mode are dropped
    endcase
  endfunction

  // Lowers the stream and lets the block drain completely.
  task automatic wait_quiet();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle. Back to back writes
  // keep wr_en high; the next pixel lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (stream_used) begin
      wait_quiet();
      stream_used = 1'b0;
    end
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    shadow_write(idx, val);
  endtask

  // Offers one pixel after a random idle gap, and returns in the time step of
  // the clock edge that accepts it.
  task automatic offer_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    if (wr_en) wr_en <= 1'b0;
    stream_used = 1'b1;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      if (s_tvalid) s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{is_write: 1'b1, reg_index: idx, value: PIX_W'(val), default: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_pixel(input logic [PIX_W-1:0] pix);
    plan_row_t row;
    row = '{value: pix, default: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_known(input logic [PIX_W-1:0] pix, input bit emit,
                                     input logic [IDX_W-1:0] idx, input bit last);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_index: '0, value: pix, fixed: 1'b1,
            fixed_emit: emit, fixed_index: idx, fixed_last: last};
    directed_plan.push_back(row);
  endfunction

  // Receiver: random ready per cycle, except during a requested long stall.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      m_tready  <= 1'b0;
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready  <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checker: every accepted word must match the oldest word still owed.
  dest_word_t oldest;
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        oldest = pending_words.pop_front();
        if (m_tdata[IDX_W-1:0] !== oldest.dest_index)
          report_mismatch("dest_index", m_tdata[IDX_W-1:0], oldest.dest_index);
        if (m_tdata[IDX_W+PIX_W-1:IDX_W] !== oldest.pixel)
          report_mismatch("pixel_out", m_tdata[IDX_W+PIX_W-1:IDX_W], oldest.pixel);
        if (m_tlast !== oldest.last)
          report_mismatch("frame_last", m_tlast, oldest.last);
      end
    end
  end

  initial begin : stimulus
    int k, n, rand_done, guard;
    int unsigned w, h;
    logic [PIX_W-1:0] pix;
    dest_word_t word;
    bit emit;

    shadow_regs = '{source_width: CFG_DATA_W'(MAX_WIDTH_DEF),
                    source_height: CFG_DATA_W'(MAX_HEIGHT_DEF),
                    view_left: '0, view_top: '0,
                    view_columns: CFG_DATA_W'(MAX_WIDTH_DEF),
                    view_rows: CFG_DATA_W'(MAX_HEIGHT_DEF),
                    rotation_mode: MODE_COPY};
    scan_col = 0;
    scan_row = 0;

    // After reset the block copies a 1024 by 1024 frame, so the first two
    // pixels land at indices 0 and 1 and neither closes the frame.
    plan_known(16'h0000, 1'b1, 20'd0, 1'b0);
    plan_known(16'hFFFF, 1'b1, 20'd1, 1'b0);
    // A frame size of zero acts as a single pixel: every pixel is a whole frame.
    plan_write(REG_SOURCE_WIDTH, '0);
    plan_write(REG_SOURCE_HEIGHT, '0);
    plan_known(16'h1234, 1'b1, 20'd0, 1'b1);
    plan_known(16'hEDCB, 1'b1, 20'd0, 1'b1);
    // Oversized frame clamps to the maximum. The write to the unused index must
    // not restart the scan, so the second pixel still lands at index 1.
    plan_write(REG_SOURCE_WIDTH, '1);
    plan_write(REG_SOURCE_HEIGHT, '1);
    plan_known(16'h00FF, 1'b1, 20'd0, 1'b0);
    plan_write(REG_UNUSED, '1);
    plan_pixel(16'h5A5A);
    // A one pixel frame inside a huge viewport turned by 180 degrees: the index
    // 2046 * 2048 wraps to its low 20 bits.
    plan_write(REG_SOURCE_WIDTH, 11'd1);
    plan_write(REG_SOURCE_HEIGHT, 11'd1);
    plan_write(REG_VIEW_LEFT, '0);
    plan_write(REG_VIEW_TOP, '0);
    plan_write(REG_VIEW_COLUMNS, '1);
    plan_write(REG_VIEW_ROWS, '1);
    plan_write(REG_ROTATION_MODE, CFG_DATA_W'(MODE_ROT180));
    plan_known(16'hFF00, 1'b1, 20'hFF000, 1'b1);
    // A 3 by 2 frame with a 2 by 2 viewport on its right side, turned by 90.
    plan_write(REG_SOURCE_WIDTH, 11'd3);
    plan_write(REG_SOURCE_HEIGHT, 11'd2);
    plan_write(REG_VIEW_LEFT, 11'd1);
    plan_write(REG_VIEW_COLUMNS, 11'd2);
    plan_write(REG_VIEW_ROWS, 11'd2);
    plan_write(REG_ROTATION_MODE, CFG_DATA_W'(MODE_ROT90));
    for (k = 0; k < 6; k++) plan_pixel(16'h0101 * (k + 1));
    // The same viewport moved one row down hangs over the bottom edge; turned by 270.
    plan_write(REG_VIEW_TOP, 11'd1);
    plan_write(REG_ROTATION_MODE, CFG_DATA_W'(MODE_ROT270));
    for (k = 0; k < 6; k++) plan_pixel(16'h8421 + k);
    // An empty viewport drops everything.
    plan_write(REG_VIEW_COLUMNS, '0);
    plan_write(REG_ROTATION_MODE, CFG_DATA_W'(MODE_ROT180));
    plan_known(16'hC3C3, 1'b0, '0, 1'b0);
    plan_known(16'h3C3C, 1'b0, '0, 1'b0);
    // A viewport that starts beyond the frame drops everything as well.
    plan_write(REG_VIEW_LEFT, 11'd1023);
    plan_write(REG_VIEW_COLUMNS, 11'd2);
    plan_known(16'h7E7E, 1'b0, '0, 1'b0);
    // Copy mode ignores the viewport.
    plan_write(REG_ROTATION_MODE, CFG_DATA_W'(MODE_COPY));
    plan_pixel(16'h0F0F);
    plan_pixel(16'hF0F0);

    tx_idle_pct = 21;
    rx_idle_pct = 63;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_write) begin
        write_reg(directed_plan[r].reg_index, CFG_DATA_W'(directed_plan[r].value));
      end else begin
        offer_pixel(directed_plan[r].value);
        emit = rotate_pixel(directed_plan[r].value, word);
        if (directed_plan[r].fixed) begin
          emit = directed_plan[r].fixed_emit;
          word = '{dest_index: directed_plan[r].fixed_index,
                   pixel: directed_plan[r].value,
                   last: directed_plan[r].fixed_last};
        end
        if (emit) pending_words.push_back(word);
      end
    end

    // Back pressure: a copied 5 by 4 frame keeps producing words while the
    // receiver stalls for a long stretch, so the block fills and stops taking
    // pixels.
    write_reg(REG_SOURCE_WIDTH, 11'd5);
    write_reg(REG_SOURCE_HEIGHT, 11'd4);
    hold_asks <= hold_asks + 1;
    for (k = 0; k < 40; k++) begin
      pix = PIX_W'($urandom);
      offer_pixel(pix);
      if (rotate_pixel(pix, word)) pending_words.push_back(word);
    end

    // Random settings, each followed mostly by whole frames and sometimes by a
    // partial one. Every setting change waits for the block to drain first.
    while (items_sent < DIRECTED_ITEMS + 40 + RANDOM_ITEMS) begin
      rand_done = items_sent - DIRECTED_ITEMS - 40;
      if (rand_done < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 21;
        rx_idle_pct = 63;
      end else if (rand_done < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 63;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (k = REG_SOURCE_WIDTH; k <= REG_ROTATION_MODE; k++) begin
        if ($urandom_range(99) < 60) write_reg(CFG_IDX_W'(k), pick_reg_value(CFG_IDX_W'(k)));
      end
      if ($urandom_range(19) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      w = clamp_size(shadow_regs.source_width, MAX_WIDTH_DEF);
      h = clamp_size(shadow_regs.source_height, MAX_HEIGHT_DEF);
      if (w * h <= 64) begin
        n = w * h * $urandom_range(3, 1);
        if ($urandom_range(4) == 0) n += $urandom_range(w * h);
      end else begin
        n = $urandom_range(60, 10);
      end
      // The last run is cut short so that the item count comes out exact.
      if (n > RANDOM_ITEMS - rand_done) n = RANDOM_ITEMS - rand_done;
      for (k = 0; k < n; k++) begin
        pix = PIX_W'($urandom);
        offer_pixel(pix);
        if (rotate_pixel(pix, word)) pending_words.push_back(word);
      end
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < END_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) report_mismatch("words never delivered", 0,
                                                   pending_words.size());
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/irag_pkg.sv
design/irag_locate.sv
design/image_rotate_address_gen_top.sv
bench/tb_top.sv
